### src/spfps_pkg.sv
// ----------------------------------------------------------------------------
// SPI flash page-program sequencer package
// Shared types, codes and helpers for the sequencer core and its step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package spfps_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Result actions
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_DONE    = 2'd2;
  localparam logic [1:0] ACT_FAIL    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PAGE_SIZE_LOG2    = 2'd0;
  localparam logic [1:0] REG_PROGRAM_OPCODE    = 2'd1;
  localparam logic [1:0] REG_FOUR_BYTE_ADDRESS = 2'd2;
  localparam logic [1:0] REG_BUSY_POLL_LIMIT   = 2'd3;

  // Flash command bytes
  localparam logic [7:0] CMD_READ_STATUS  = 8'h05;
  localparam logic [7:0] CMD_WRITE_ENABLE = 8'h06;
  localparam logic [7:0] CMD_DUMMY        = 8'h00;

  // Largest supported page, as log2 of bytes
  localparam logic [4:0] PAGE_LOG2_MAX = 5'd16;

  // Reset values of the configuration registers
  localparam logic [4:0]  PAGE_SIZE_LOG2_RST    = 5'd8;
  localparam logic [7:0]  PROGRAM_OPCODE_RST    = 8'h02;
  localparam logic        FOUR_BYTE_ADDRESS_RST = 1'b0;
  localparam logic [15:0] BUSY_POLL_LIMIT_RST   = 16'd1000;

  // Most results one input transaction can cause
  localparam int MAX_RESULTS = 7;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_POLL = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       keep_selected;
    logic       want_reply;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] flash_address;
    logic [31:0] bytes_remaining;
    logic [16:0] chunk_remaining;
    logic [15:0] poll_count;
  } job_state_t;

  typedef struct packed {
    logic [4:0]  page_size_log2;
    logic [7:0]  program_opcode;
    logic        four_byte_address;
    logic [15:0] busy_poll_limit;
  } cfg_t;

  function automatic result_t mk_send(input logic [7:0] b, input logic keep,
                                      input logic reply);
    result_t r;
    r.action        = ACT_SEND;
    r.tx_byte       = b;
    r.keep_selected = keep;
    r.want_reply    = reply;
    return r;
  endfunction

  function automatic result_t mk_ctrl(input logic [1:0] act);
    result_t r;
    r.action        = act;
    r.tx_byte       = 8'h00;
    r.keep_selected = 1'b0;
    r.want_reply    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/spfps_step.sv
// ----------------------------------------------------------------------------
// SPI flash page-program sequencer step logic
// Works out the full list of results and the next job state for one input.
// ----------------------------------------------------------------------------
`default_nettype none

module spfps_step (
  input  spfps_pkg::cfg_t                          cfg,
  input  spfps_pkg::job_state_t                    st,
  input  logic [1:0]                               kind,
  input  logic [31:0]                              start_offset,
  input  logic [31:0]                              byte_count,
  input  logic [7:0]                               payload_byte,
  output spfps_pkg::result_t [spfps_pkg::MAX_RESULTS-1:0] res,
  output logic [spfps_pkg::CNT_W-1:0]              res_count,
  output spfps_pkg::job_state_t                    st_nxt
);
  import spfps_pkg::*;

  logic [4:0]  lg;
  logic [16:0] page_bytes;
  logic [16:0] room;
  logic        last_of_chunk;
  logic [31:0] a;

  always_comb begin
    lg            = (cfg.page_size_log2 > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX
                                                         : cfg.page_size_log2;
    page_bytes    = 17'(1) << lg;
    room          = page_bytes - (st.flash_address[16:0] & (page_bytes - 17'd1));
    last_of_chunk = (st.chunk_remaining <= 17'd1);
    a             = st.flash_address;
  end

  always_comb begin
    res       = '0;
    res_count = '0;
    st_nxt    = st;
    unique case (kind)
      KIND_START: begin
        if (st.phase == PH_IDLE) begin
          res[0]                 = mk_send(CMD_READ_STATUS, 1'b1, 1'b0);
          res[1]                 = mk_send(CMD_DUMMY, 1'b1, 1'b1);
          res_count              = CNT_W'(2);
          st_nxt.flash_address   = start_offset;
          st_nxt.bytes_remaining = byte_count;
          st_nxt.chunk_remaining = '0;
          st_nxt.poll_count      = 16'd1;
          st_nxt.phase           = PH_POLL;
        end
      end
      KIND_DATA: begin
        if (st.phase == PH_DATA) begin
          res[0]                 = mk_send(payload_byte, !last_of_chunk, 1'b0);
          res_count              = CNT_W'(1);
          st_nxt.chunk_remaining = last_of_chunk ? 17'd0 : st.chunk_remaining - 17'd1;
          st_nxt.bytes_remaining = st.bytes_remaining - 32'd1;
          st_nxt.flash_address   = st.flash_address + 32'd1;
          if (last_of_chunk) begin
            // The chunk is complete: chip select drops and the busy poll begins.
            res[1]            = mk_send(CMD_READ_STATUS, 1'b1, 1'b0);
            res[2]            = mk_send(CMD_DUMMY, 1'b1, 1'b1);
            res_count         = CNT_W'(3);
            st_nxt.poll_count = 16'd1;
            st_nxt.phase      = PH_POLL;
          end
        end
      end
      KIND_STATUS: begin
        if (st.phase == PH_POLL) begin
          if (!payload_byte[0]) begin
            res[0] = mk_ctrl(ACT_RELEASE);
            if (st.bytes_remaining == 32'd0) begin
              res[1]       = mk_ctrl(ACT_DONE);
              res_count    = CNT_W'(2);
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.chunk_remaining = (st.bytes_remaining < {15'd0, room})
                                       ? st.bytes_remaining[16:0] : room;
              res[1] = mk_send(CMD_WRITE_ENABLE, 1'b0, 1'b0);
              res[2] = mk_send(cfg.program_opcode, 1'b1, 1'b0);
              if (cfg.four_byte_address) begin
                res[3]    = mk_send(a[31:24], 1'b1, 1'b0);
                res[4]    = mk_send(a[23:16], 1'b1, 1'b0);
                res[5]    = mk_send(a[15:8], 1'b1, 1'b0);
                res[6]    = mk_send(a[7:0], 1'b1, 1'b0);
                res_count = CNT_W'(7);
              end else begin
                res[3]    = mk_send(a[23:16], 1'b1, 1'b0);
                res[4]    = mk_send(a[15:8], 1'b1, 1'b0);
                res[5]    = mk_send(a[7:0], 1'b1, 1'b0);
                res_count = CNT_W'(6);
              end
              st_nxt.phase = PH_DATA;
            end
          end else if (st.poll_count >= cfg.busy_poll_limit) begin
            res[0]       = mk_ctrl(ACT_RELEASE);
            res[1]       = mk_ctrl(ACT_FAIL);
            res_count    = CNT_W'(2);
            st_nxt.phase = PH_IDLE;
          end else begin
            res[0]            = mk_send(CMD_DUMMY, 1'b1, 1'b1);
            res_count         = CNT_W'(1);
            st_nxt.poll_count = st.poll_count + 16'd1;
          end
        end
      end
      default: begin
        res_count = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/spi_flash_page_program_sequencer_core.sv
// ----------------------------------------------------------------------------
// SPI flash page-program sequencer core
// Turns start, data and status transactions into SPI byte actions for a
// NOR flash page-program job, with busy polling and page-boundary chunking.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Carries
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | kind, offset, count, byte
//  out_    | output    | out_valid/out_stall| action, byte, select, reply, last
//  cfg_    | input     | cfg_valid/cfg_ready| register index and write data
//
// Each accepted transaction is worked out combinationally and its results, up to
// seven, are loaded into an output shift register that hands out one per cycle
// while out_stall is low. The next transaction is taken in the cycle the last
// result of the previous one leaves. Synchronous, active-low reset idles the job
// and empties the output; an output stall holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_flash_page_program_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_start_offset,
  input  logic [31:0] in_byte_count,
  input  logic [7:0]  in_payload_byte,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [7:0]  out_tx_byte,
  output logic        out_keep_selected,
  output logic        out_want_reply,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import spfps_pkg::*;

  // Configuration registers: user writes only while the job is idle; not enforced.
  cfg_t cfg_r;

  // Job state.
  job_state_t st_r;
  job_state_t st_nxt;

  // Output shift register: entry 0 is the result on offer.
  result_t [MAX_RESULTS-1:0] res_q_r;
  logic [CNT_W-1:0]          res_cnt_r;
  logic [CNT_W-1:0]          res_cnt_nxt;

  result_t [MAX_RESULTS-1:0] step_res;
  logic [CNT_W-1:0]          step_count;

  logic in_accept;
  logic out_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_size_log2    <= PAGE_SIZE_LOG2_RST;
      cfg_r.program_opcode    <= PROGRAM_OPCODE_RST;
      cfg_r.four_byte_address <= FOUR_BYTE_ADDRESS_RST;
      cfg_r.busy_poll_limit   <= BUSY_POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAGE_SIZE_LOG2:    cfg_r.page_size_log2    <= cfg_data[4:0];
        REG_PROGRAM_OPCODE:    cfg_r.program_opcode    <= cfg_data[7:0];
        REG_FOUR_BYTE_ADDRESS: cfg_r.four_byte_address <= cfg_data[0];
        REG_BUSY_POLL_LIMIT:   cfg_r.busy_poll_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencing decisions for one transaction.
  spfps_step u_step (
    .cfg          (cfg_r),
    .st           (st_r),
    .kind         (in_kind),
    .start_offset (in_start_offset),
    .byte_count   (in_byte_count),
    .payload_byte (in_payload_byte),
    .res          (step_res),
    .res_count    (step_count),
    .st_nxt       (st_nxt)
  );

  // A new transaction may enter once the output register is empty, or in
  // the cycle its final entry is being taken.
  assign out_valid = (res_cnt_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign in_stall  = (res_cnt_r > CNT_W'(1)) || ((res_cnt_r == CNT_W'(1)) && out_stall);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (in_accept) begin
      res_cnt_nxt = step_count;
    end else if (out_pop) begin
      res_cnt_nxt = res_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r                <= '0;
      st_r.phase               <= PH_IDLE;
      st_r.flash_address       <= '0;
      st_r.bytes_remaining     <= '0;
      st_r.chunk_remaining     <= '0;
      st_r.poll_count          <= '0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
      if (in_accept) begin
        st_r <= st_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_q_r <= step_res;
    end else if (out_pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_q_r[i] <= res_q_r[i+1];
      end
    end
  end

  assign out_action        = res_q_r[0].action;
  assign out_tx_byte       = res_q_r[0].tx_byte;
  assign out_keep_selected = res_q_r[0].keep_selected;
  assign out_want_reply    = res_q_r[0].want_reply;
  // The final entry of a group is the last result of its transaction.
  assign out_last          = (res_cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page-program sequencer testbench
// Drives start, data and status transactions into the sequencer core, predicts
// the SPI byte actions each one causes, and checks every result transaction
// in order. A short directed table opens the run and four randomised phases
// with different register settings and idling patterns follow it.
// ----------------------------------------------------------------------------

module tb;
  import spfps_pkg::*;

  // Kind code that the block has no use for; it must be ignored everywhere.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Cycles to let pass after the last expected result before a register write.
  localparam int SETTLE_CYCLES   = 8;
  // Cycles to let pass at the very end, once nothing is expected any more.
  localparam int TAIL_CYCLES     = 20;
  // Cycles without any accepted transaction before the run is abandoned.
  localparam int QUIET_LIMIT     = 2000;
  // Well-formed random transactions per randomised phase.
  localparam int ITEMS_PER_PHASE = 45;

  // One expected result transaction: the package's result fields plus the
  // marker of the final result caused by an input transaction.
  typedef struct packed {
    result_t res;
    logic    last;
  } spi_action_t;

  localparam spi_action_t NIL_ACT = '0;

  // One row of the directed table. A row either carries an input transaction
  // or a single register write (index in kind, data in the low count bits).
  // Where n_typed is not negative, the listed results are cross-checked
  // against what the predictor makes of the row.
  typedef struct {
    bit          is_cfg;
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [31:0] count;
    logic [7:0]  payload;
    int          n_typed;
    spi_action_t typed0;
    spi_action_t typed1;
  } stim_row_t;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  wire         in_stall;
  logic [1:0]  in_kind           = KIND_START;
  logic [31:0] in_start_offset   = '0;
  logic [31:0] in_byte_count     = '0;
  logic [7:0]  in_payload_byte   = '0;
  wire         out_valid;
  logic        out_stall         = 1'b0;
  wire  [1:0]  out_action;
  wire  [7:0]  out_tx_byte;
  wire         out_keep_selected;
  wire         out_want_reply;
  wire         out_last;
  logic        cfg_valid         = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index         = REG_PAGE_SIZE_LOG2;
  logic [15:0] cfg_data          = '0;

  spi_flash_page_program_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_start_offset   (in_start_offset),
    .in_byte_count     (in_byte_count),
    .in_payload_byte   (in_payload_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_tx_byte       (out_tx_byte),
    .out_keep_selected (out_keep_selected),
    .out_want_reply    (out_want_reply),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Predictor's copy of the configuration registers, at their reset values.
  logic [4:0]  page_log2   = PAGE_SIZE_LOG2_RST;
  logic [7:0]  prog_opcode = PROGRAM_OPCODE_RST;
  logic        addr4       = FOUR_BYTE_ADDRESS_RST;
  logic [15:0] poll_limit  = BUSY_POLL_LIMIT_RST;

  // Predictor's copy of the job state.
  phase_t      job_phase  = PH_IDLE;
  logic [31:0] job_addr   = '0;
  logic [31:0] job_left   = '0;
  logic [31:0] chunk_left = '0;
  logic [15:0] poll_reads = '0;

  // Results predicted for the most recent input transaction, and every
  // result still awaited from the block, oldest first.
  spi_action_t step_results[$];
  spi_action_t pending_spi_actions[$];

  int fail_count   = 0;
  int quiet_cycles = 0;
  int idle_in_pct  = 0;
  int stall_pct    = 0;

  // The clock runs with a 2 ns period from time zero.
  initial forever #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic spi_action_t spi_send(input logic [7:0] b, input logic keep,
                                           input logic reply, input logic last);
    spi_action_t a;
    a.res.action        = ACT_SEND;
    a.res.tx_byte       = b;
    a.res.keep_selected = keep;
    a.res.want_reply    = reply;
    a.last              = last;
    return a;
  endfunction

  function automatic spi_action_t spi_ctrl(input logic [1:0] act, input logic last);
    spi_action_t a;
    a       = '0;
    a.res.action = act;
    a.last  = last;
    return a;
  endfunction

  // The busy poll opens with read-status and one dummy byte whose reply the
  // sender must hand back as a status transaction.
  task automatic begin_status_poll();
    step_results.push_back(spi_send(CMD_READ_STATUS, 1'b1, 1'b0, 1'b0));
    step_results.push_back(spi_send(CMD_DUMMY, 1'b1, 1'b1, 1'b0));
    poll_reads = 16'd1;
    job_phase  = PH_POLL;
  endtask

  // Works out the results of one accepted input transaction, advances the
  // predicted state and queues the results behind those still awaited.
  task automatic predict_spi_actions(input logic [1:0] kind, input logic [31:0] offset,
                                     input logic [31:0] count, input logic [7:0] pay);
    logic [4:0]  lg;
    logic [31:0] page_bytes;
    logic [31:0] room;
    bit          chunk_end;
    step_results.delete();
    case (kind)
      KIND_START: begin
        // A start is only taken while no job runs.
        if (job_phase == PH_IDLE) begin
          job_addr   = offset;
          job_left   = count;
          chunk_left = '0;
          begin_status_poll();
        end
      end
      KIND_DATA: begin
        if (job_phase == PH_DATA) begin
          // The final byte of a chunk drops chip select and the poll
          // follows straight away.
          chunk_end = (chunk_left <= 32'd1);
          step_results.push_back(spi_send(pay, !chunk_end, 1'b0, 1'b0));
          chunk_left = chunk_end ? 32'd0 : chunk_left - 32'd1;
          job_left   = job_left - 32'd1;
          job_addr   = job_addr + 32'd1;
          if (chunk_end) begin
            begin_status_poll();
          end
        end
      end
      KIND_STATUS: begin
        if (job_phase == PH_POLL) begin
          if (!pay[0]) begin
            step_results.push_back(spi_ctrl(ACT_RELEASE, 1'b0));
            if (job_left == 32'd0) begin
              step_results.push_back(spi_ctrl(ACT_DONE, 1'b0));
              job_phase = PH_IDLE;
            end else begin
              // The chunk is clipped at the page boundary; pages above the
              // largest supported size are treated as the largest.
              lg         = (page_log2 > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_log2;
              page_bytes = 32'd1 << lg;
              room       = page_bytes - (job_addr & (page_bytes - 32'd1));
              chunk_left = (job_left < room) ? job_left : room;
              step_results.push_back(spi_send(CMD_WRITE_ENABLE, 1'b0, 1'b0, 1'b0));
              step_results.push_back(spi_send(prog_opcode, 1'b1, 1'b0, 1'b0));
              if (addr4) begin
                step_results.push_back(spi_send(job_addr[31:24], 1'b1, 1'b0, 1'b0));
              end
              step_results.push_back(spi_send(job_addr[23:16], 1'b1, 1'b0, 1'b0));
              step_results.push_back(spi_send(job_addr[15:8], 1'b1, 1'b0, 1'b0));
              step_results.push_back(spi_send(job_addr[7:0], 1'b1, 1'b0, 1'b0));
              job_phase = PH_DATA;
            end
          end else if (poll_reads >= poll_limit) begin
            // Still busy with the poll limit used up: the job fails. A limit
            // of zero behaves like one, which this comparison gives for free.
            step_results.push_back(spi_ctrl(ACT_RELEASE, 1'b0));
            step_results.push_back(spi_ctrl(ACT_FAIL, 1'b0));
            job_phase = PH_IDLE;
          end else begin
            step_results.push_back(spi_send(CMD_DUMMY, 1'b1, 1'b1, 1'b0));
            poll_reads = poll_reads + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
    if (step_results.size() != 0) begin
      step_results[step_results.size() - 1].last = 1'b1;
    end
    foreach (step_results[k]) begin
      pending_spi_actions.push_back(step_results[k]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Everything is sampled at the rising edge, where the inputs have been
  // stable since the falling edge before it. The input side is handled first
  // so that a transaction and its results can never be taken out of order.
  always @(posedge clk) begin : monitor
    spi_action_t want;
    bit          in_taken;
    bit          out_taken;
    if (rst_n) begin
      in_taken  = in_valid && !in_stall;
      out_taken = out_valid && !out_stall;
      if (in_taken) begin
        predict_spi_actions(in_kind, in_start_offset, in_byte_count, in_payload_byte);
      end
      if (out_taken) begin
        if (pending_spi_actions.size() == 0) begin
          $error("result transaction with nothing expected: action %0d, byte %0h",
                 out_action, out_tx_byte);
          fail_count++;
        end else begin
          want = pending_spi_actions.pop_front();
          check_field("action", 8'(want.res.action), 8'(out_action));
          check_field("tx_byte", want.res.tx_byte, out_tx_byte);
          check_field("keep_selected", 8'(want.res.keep_selected), 8'(out_keep_selected));
          check_field("want_reply", 8'(want.res.want_reply), 8'(out_want_reply));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
      // The watchdog only counts cycles in which no channel moved anything.
      if (in_taken || out_taken || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Abandons the run if the block stops moving transactions altogether.
  initial begin
    wait (rst_n);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // The receiver stalls at random on every falling edge, at the rate that
  // the current phase sets.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offers one input transaction and holds it until it has been taken. It is
  // entered and left at a falling edge; valid is left high on return, so the
  // caller either offers the next transaction or lowers valid itself.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] offset,
                           input logic [31:0] count, input logic [7:0] pay);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_start_offset <= offset;
    in_byte_count   <= count;
    in_payload_byte <= pay;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Lowers both request lines and waits until every expected result has
  // arrived, then for a number of further cycles.
  task automatic hold_until_drained(input int extra);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_spi_actions.size() != 0);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register and mirrors it into the predictor at the same edge.
  // As with send_item, valid is left high for the caller to deal with.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PAGE_SIZE_LOG2:    page_log2   = val[4:0];
      REG_PROGRAM_OPCODE:    prog_opcode = val[7:0];
      REG_FOUR_BYTE_ADDRESS: addr4       = val[0];
      REG_BUSY_POLL_LIMIT:   poll_limit  = val;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [4:0] pg, input logic [7:0] op,
                           input logic four, input logic [15:0] lim);
    hold_until_drained(SETTLE_CYCLES);
    write_reg(REG_PAGE_SIZE_LOG2, 16'(pg));
    write_reg(REG_PROGRAM_OPCODE, 16'(op));
    write_reg(REG_FOUR_BYTE_ADDRESS, 16'(four));
    write_reg(REG_BUSY_POLL_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // Picks the next transaction from the predicted job phase, so that most of
  // the traffic is what a real host would send: starts when idle, status
  // replies while polling and data bytes in the data phase. With noise
  // allowed, about one in ten is a transaction the block must ignore.
  task automatic random_item(input bit noise_ok, input bit huge_ok, output bit counted);
    logic [1:0]  kind;
    logic [1:0]  wanted;
    logic [31:0] offset;
    logic [31:0] count;
    logic [7:0]  pay;
    offset = $urandom();
    count  = $urandom();
    pay    = 8'($urandom());
    case (job_phase)
      PH_POLL: wanted = KIND_STATUS;
      PH_DATA: wanted = KIND_DATA;
      default: wanted = KIND_START;
    endcase
    counted = !(noise_ok && ($urandom_range(99) < 10));
    if (!counted) begin
      do kind = 2'($urandom_range(3)); while (kind == wanted);
    end else begin
      kind = wanted;
      if (wanted == KIND_START) begin
        // Mostly short jobs; where allowed, now and then a job with a full
        // 32-bit count, which can only end through the poll limit.
        if (!(huge_ok && ($urandom_range(99) < 20))) begin
          count = $urandom_range(0, ($urandom_range(99) < 80) ? 12 : 40);
        end
        // Half of the jobs begin just short of a 256-byte boundary.
        if ($urandom_range(1)) begin
          offset[7:0] = 8'hf8 | 8'($urandom_range(7));
        end
      end else if (wanted == KIND_STATUS) begin
        // Long jobs see mostly busy replies so that they fail soon.
        pay[0] = ($urandom_range(99) < ((job_left > 32'd1000) ? 70 : 35));
      end
    end
    send_item(kind, offset, count, pay);
  endtask

  // One randomised phase: new register settings, an idling pattern, a batch
  // of transactions with one full pause half way, then the running job is
  // brought to its end with well-formed traffic only.
  task automatic run_phase(input int idle_pct, input int stall, input logic [4:0] pg,
                           input logic [7:0] op, input logic four,
                           input logic [15:0] lim, input bit huge_ok);
    int items_done;
    bit counted;
    configure(pg, op, four, lim);
    idle_in_pct = idle_pct;
    stall_pct   = stall;
    items_done  = 0;
    while (items_done < ITEMS_PER_PHASE) begin
      random_item(1'b1, huge_ok, counted);
      if (counted) begin
        items_done++;
        if (items_done == ITEMS_PER_PHASE / 2) begin
          hold_until_drained(0);
        end
      end
    end
    while (job_phase != PH_IDLE) begin
      random_item(1'b0, huge_ok, counted);
    end
  endtask

  function automatic stim_row_t item_row(input logic [1:0] kind, input logic [31:0] offset,
                                         input logic [31:0] count, input logic [7:0] pay,
                                         input int n, input spi_action_t t0,
                                         input spi_action_t t1);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.kind    = kind;
    r.offset  = offset;
    r.count   = count;
    r.payload = pay;
    r.n_typed = n;
    r.typed0  = t0;
    r.typed1  = t1;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    stim_row_t r;
    r         = item_row(idx, '0, 32'(val), '0, -1, NIL_ACT, NIL_ACT);
    r.is_cfg  = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    stim_row_t rows[$];

    // Out of reset: misplaced transactions are ignored, an empty job polls until
    // a ready reply and then finishes, and a start during a job is ignored.
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'hff, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_UNUSED, '1, '1, 8'hff, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_START, '0, '0, 8'h00, 2,
                            spi_send(CMD_READ_STATUS, 1'b1, 1'b0, 1'b0),
                            spi_send(CMD_DUMMY, 1'b1, 1'b1, 1'b1)));
    rows.push_back(item_row(KIND_START, '1, '1, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_UNUSED, '0, '0, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h01, 1,
                            spi_send(CMD_DUMMY, 1'b1, 1'b1, 1'b1), NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'hfe, 2,
                            spi_ctrl(ACT_RELEASE, 1'b0), spi_ctrl(ACT_DONE, 1'b1)));

    // One-byte pages, four address bytes and the tightest poll limit. The
    // job starts at the top of the address space with the largest count, so
    // the second chunk shows the address wrapping round to zero.
    rows.push_back(reg_row(REG_PAGE_SIZE_LOG2, 16'd0));
    rows.push_back(reg_row(REG_PROGRAM_OPCODE, 16'h00ff));
    rows.push_back(reg_row(REG_FOUR_BYTE_ADDRESS, 16'd1));
    rows.push_back(reg_row(REG_BUSY_POLL_LIMIT, 16'd1));
    rows.push_back(item_row(KIND_START, '1, '1, 8'h00, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'hfe, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_START, '0, 32'd5, 8'h00, 0, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'h00, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'hfe, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'hff, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h01, 2,
                            spi_ctrl(ACT_RELEASE, 1'b0), spi_ctrl(ACT_FAIL, 1'b1)));

    // Oversized page setting, three address bytes and a poll limit of zero.
    // The job crosses a 64 KiB boundary and then fails on the first busy read.
    rows.push_back(reg_row(REG_PAGE_SIZE_LOG2, 16'd31));
    rows.push_back(reg_row(REG_PROGRAM_OPCODE, 16'h0000));
    rows.push_back(reg_row(REG_FOUR_BYTE_ADDRESS, 16'd0));
    rows.push_back(reg_row(REG_BUSY_POLL_LIMIT, 16'd0));
    rows.push_back(item_row(KIND_START, 32'h00ff_fffe, 32'd3, 8'h00, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h00, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'ha5, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'h5a, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'h00, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_DATA, '0, '0, 8'hff, -1, NIL_ACT, NIL_ACT));
    rows.push_back(item_row(KIND_STATUS, '0, '0, 8'hff, 2,
                            spi_ctrl(ACT_RELEASE, 1'b0), spi_ctrl(ACT_FAIL, 1'b1)));

    // Synchronous reset, released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The directed table runs without any idling. Register rows wait for the
    // block to settle first; a run of them shares one write burst.
    for (int i = 0; i < rows.size(); i++) begin
      if (rows[i].is_cfg) begin
        if (i == 0 || !rows[i - 1].is_cfg) begin
          hold_until_drained(SETTLE_CYCLES);
        end
        write_reg(rows[i].kind, rows[i].count[15:0]);
        if (i + 1 == rows.size() || !rows[i + 1].is_cfg) begin
          cfg_valid <= 1'b0;
        end
      end else begin
        send_item(rows[i].kind, rows[i].offset, rows[i].count, rows[i].payload);
        // The monitor has predicted this transaction at the edge that took it.
        if (rows[i].n_typed >= 0) begin
          if (step_results.size() != rows[i].n_typed) begin
            $error("row %0d result count: expected %0d, got %0d",
                   i, rows[i].n_typed, step_results.size());
            fail_count++;
          end else begin
            for (int j = 0; j < rows[i].n_typed; j++) begin
              if (step_results[j] !== ((j == 0) ? rows[i].typed0 : rows[i].typed1)) begin
                $error("row %0d result %0d: expected %0h, got %0h", i, j,
                       (j == 0) ? rows[i].typed0 : rows[i].typed1, step_results[j]);
                fail_count++;
              end
            end
          end
        end
      end
    end

    // Randomised phases: no idling, a lazy sender, a stalling receiver, and
    // both at a lower rate. Long jobs only run where pages are tiny and the
    // poll limit is low enough to end them.
    run_phase(0, 0, 5'd2, 8'($urandom_range(255)), 1'b1, 16'd3, 1'b1);
    run_phase(45, 0, 5'd8, PROGRAM_OPCODE_RST, 1'b0, 16'hffff, 1'b0);
    run_phase(0, 45, 5'd16, 8'($urandom_range(255)), 1'b1, 16'd2, 1'b0);
    run_phase(14, 14, 5'd0, 8'($urandom_range(255)), 1'b0, 16'd1, 1'b1);

    hold_until_drained(TAIL_CYCLES);
    if (fail_count == 0 && pending_spi_actions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
